>>> rtl/jkve_pkg.sv
// ----------------------------------------------------------------------------
// jkve_pkg
// shared types, constants and codes of the json key/value extractor
// ----------------------------------------------------------------------------
package jkve_pkg;

  localparam int KEY_BYTES   = 8;
  localparam int LENGTH_BITS = 8;
  localparam int DEPTH_BITS  = 8;

  localparam int WIN_W  = KEY_BYTES * 8;
  localparam int KLEN_W = 4;
  localparam int FILL_W = $clog2(KEY_BYTES + 1);
  localparam int CIDX_W = 2;

  localparam logic [CIDX_W-1:0] CFG_KEY_PATTERN = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_KEY_LENGTH  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MAX_LENGTH  = 2'd2;

  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [4:0] {
    PH_SEARCH = 5'b00001,
    PH_COLON  = 5'b00010,
    PH_SPACE  = 5'b00100,
    PH_COPY   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_OBJECT = 2'd0,
    KIND_QUOTED = 2'd1,
    KIND_ARRAY  = 2'd2,
    KIND_BARE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       value_done;
    logic       key_found;
    logic [7:0] value_length;
  } out_item_t;

  typedef struct packed {
    logic [63:0]       key_pattern;
    logic [KLEN_W-1:0] key_length;
    logic [7:0]        max_value_length;
  } cfg_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } match_ctrl_t;

endpackage

>>> rtl/jkve_key_match.sv
// ----------------------------------------------------------------------------
// jkve_key_match
// sliding byte window and key compare against the configured pattern
// ----------------------------------------------------------------------------
module jkve_key_match (
  input  logic                 clk,
  input  logic                 rst_n,
  input  jkve_pkg::match_ctrl_t ctrl,
  input  logic [7:0]           text_byte,
  input  jkve_pkg::cfg_t       cfg,
  output logic                 match
);

  logic [jkve_pkg::WIN_W-1:0]    window_r, window_nxt;
  logic [jkve_pkg::FILL_W-1:0]   fill_r, fill_nxt;
  logic [jkve_pkg::KLEN_W-1:0]   len_eff;
  logic [jkve_pkg::KLEN_W-1:0]   len_rem;
  logic [jkve_pkg::KLEN_W+2:0]   shift_amt;
  logic [jkve_pkg::WIN_W-1:0]    win_shift;
  logic [jkve_pkg::WIN_W-1:0]    pat_mask;

  always_comb begin
    len_eff = cfg.key_length;
    if (cfg.key_length == '0) begin
      len_eff = jkve_pkg::KLEN_W'(1);
    end else if (cfg.key_length > jkve_pkg::KLEN_W'(jkve_pkg::KEY_BYTES)) begin
      len_eff = jkve_pkg::KLEN_W'(jkve_pkg::KEY_BYTES);
    end
    len_rem   = jkve_pkg::KLEN_W'(jkve_pkg::KEY_BYTES) - len_eff;
    shift_amt = {len_rem, 3'b000};
  end

  always_comb begin
    window_nxt = {text_byte, window_r[jkve_pkg::WIN_W-1:8]};
    fill_nxt   = fill_r;
    if (fill_r < jkve_pkg::FILL_W'(jkve_pkg::KEY_BYTES)) begin
      fill_nxt = fill_r + 1'b1;
    end
    win_shift = window_nxt >> shift_amt;
    pat_mask  = {jkve_pkg::WIN_W{1'b1}} >> shift_amt;
    match = (jkve_pkg::KLEN_W'(fill_nxt) >= len_eff) &&
            (win_shift == (cfg.key_pattern[jkve_pkg::WIN_W-1:0] & pat_mask));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      window_r <= '0;
      fill_r   <= '0;
    end else if (ctrl.advance) begin
      window_r <= window_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

>>> rtl/jkve_extract_ctrl.sv
// ----------------------------------------------------------------------------
// jkve_extract_ctrl
// phase sequencing, value classification and byte copy decisions
// ----------------------------------------------------------------------------
module jkve_extract_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  jkve_pkg::in_item_t    item,
  input  jkve_pkg::cfg_t        cfg,
  input  logic                  match,
  output jkve_pkg::match_ctrl_t mctrl,
  output logic                  res_valid,
  output jkve_pkg::out_item_t   res
);

  localparam int LB    = jkve_pkg::LENGTH_BITS;
  localparam int DB    = jkve_pkg::DEPTH_BITS;
  localparam int LIM_W = LB + 8;
  localparam logic [DB-1:0] DEPTH_MAX = '1;

  jkve_pkg::phase_t phase_r, phase_nxt;
  jkve_pkg::kind_t  kind_r, kind_nxt;
  logic [DB-1:0]    depth_r, depth_nxt;
  logic [LB-1:0]    cnt_r, cnt_nxt;

  logic [LIM_W-1:0] max_ext;
  logic [LIM_W-1:0] cap_ext;
  logic [LB-1:0]    lim;
  logic [7:0]       b;
  logic             do_copy;
  logic             emit;
  logic             emit_byte;
  logic             emit_done;
  logic             emit_found;
  logic [LIM_W-1:0] cnt_ext;

  always_comb begin
    max_ext = LIM_W'(cfg.max_value_length);
    cap_ext = LIM_W'({LB{1'b1}});
    lim     = (max_ext > cap_ext) ? LB'(cap_ext) : LB'(max_ext);
  end

  always_comb begin
    b          = item.text_byte;
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    depth_nxt  = depth_r;
    cnt_nxt    = cnt_r;
    do_copy    = 1'b0;
    emit       = 1'b0;
    emit_byte  = 1'b0;
    emit_done  = 1'b0;
    emit_found = 1'b1;
    mctrl.advance = 1'b0;
    mctrl.clear   = 1'b0;

    if (accept && item.end_of_text) begin
      mctrl.clear = 1'b1;
      if (phase_r == jkve_pkg::PH_SEARCH) begin
        cnt_nxt    = '0;
        emit       = 1'b1;
        emit_done  = 1'b1;
        emit_found = 1'b0;
      end else if (phase_r != jkve_pkg::PH_DONE) begin
        emit      = 1'b1;
        emit_done = 1'b1;
      end
    end else if (accept) begin
      unique case (phase_r)
        jkve_pkg::PH_SEARCH: begin
          mctrl.advance = 1'b1;
          if (match) phase_nxt = jkve_pkg::PH_COLON;
        end
        jkve_pkg::PH_COLON: begin
          if (b == jkve_pkg::CH_COLON) phase_nxt = jkve_pkg::PH_SPACE;
        end
        jkve_pkg::PH_SPACE: begin
          if (b != jkve_pkg::CH_SPACE && b != jkve_pkg::CH_TAB) begin
            phase_nxt = jkve_pkg::PH_COPY;
            depth_nxt = '0;
            if (b == jkve_pkg::CH_QUOTE) begin
              kind_nxt = jkve_pkg::KIND_QUOTED;
              if (cnt_r >= lim) begin
                phase_nxt = jkve_pkg::PH_DONE;
                emit      = 1'b1;
                emit_done = 1'b1;
              end
            end else begin
              if (b == jkve_pkg::CH_LBRACE) kind_nxt = jkve_pkg::KIND_OBJECT;
              else if (b == jkve_pkg::CH_LBRACK) kind_nxt = jkve_pkg::KIND_ARRAY;
              else kind_nxt = jkve_pkg::KIND_BARE;
              do_copy = 1'b1;
            end
          end
        end
        jkve_pkg::PH_COPY: begin
          do_copy = 1'b1;
        end
        jkve_pkg::PH_DONE: begin
        end
        default: begin
        end
      endcase
    end

    if (do_copy) begin
      if (cnt_nxt >= lim) begin
        phase_nxt = jkve_pkg::PH_DONE;
        emit      = 1'b1;
        emit_done = 1'b1;
      end else if (b == jkve_pkg::CH_BSLASH) begin
        emit = 1'b0;
      end else if (kind_nxt == jkve_pkg::KIND_OBJECT) begin
        if (b == jkve_pkg::CH_LBRACE && depth_nxt < DEPTH_MAX) begin
          depth_nxt = depth_nxt + 1'b1;
        end
        if (b == jkve_pkg::CH_RBRACE) begin
          if (depth_nxt == '0) begin
            phase_nxt = jkve_pkg::PH_DONE;
            emit      = 1'b1;
            emit_done = 1'b1;
          end else begin
            depth_nxt = depth_nxt - 1'b1;
            cnt_nxt   = cnt_nxt + 1'b1;
            emit      = 1'b1;
            emit_byte = 1'b1;
            emit_done = (depth_nxt == '0) || (cnt_nxt >= lim);
          end
        end else begin
          cnt_nxt   = cnt_nxt + 1'b1;
          emit      = 1'b1;
          emit_byte = 1'b1;
          emit_done = cnt_nxt >= lim;
        end
      end else if ((kind_nxt == jkve_pkg::KIND_QUOTED && b == jkve_pkg::CH_QUOTE) ||
                   (kind_nxt == jkve_pkg::KIND_ARRAY && b == jkve_pkg::CH_RBRACK) ||
                   (kind_nxt == jkve_pkg::KIND_BARE && b == jkve_pkg::CH_COMMA)) begin
        phase_nxt = jkve_pkg::PH_DONE;
        emit      = 1'b1;
        emit_done = 1'b1;
      end else begin
        cnt_nxt   = cnt_nxt + 1'b1;
        emit      = 1'b1;
        emit_byte = 1'b1;
        emit_done = cnt_nxt >= lim;
      end
      if (emit_byte && emit_done) phase_nxt = jkve_pkg::PH_DONE;
    end

    cnt_ext          = LIM_W'(cnt_nxt);
    res_valid        = emit;
    res.value_byte   = emit_byte ? b : 8'h00;
    res.byte_valid   = emit_byte;
    res.value_done   = emit_done;
    res.key_found    = emit_found;
    res.value_length = cnt_ext[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jkve_pkg::PH_SEARCH;
      kind_r  <= jkve_pkg::KIND_OBJECT;
      depth_r <= '0;
      cnt_r   <= '0;
    end else if (accept && item.end_of_text) begin
      phase_r <= jkve_pkg::PH_SEARCH;
      kind_r  <= jkve_pkg::KIND_OBJECT;
      depth_r <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      depth_r <= depth_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_eot_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.end_of_text |=> phase_r == jkve_pkg::PH_SEARCH && cnt_r == '0)
    else $error("terminator did not restart the search");

  a_not_found_shape: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.key_found |-> res.value_done && !res.byte_valid &&
                                    res.value_length == 8'h00)
    else $error("not-found result malformed");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !item.end_of_text && phase_r == jkve_pkg::PH_DONE |-> !res_valid)
    else $error("result after end of extraction");

  a_depth_phase: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r != '0 |-> phase_r == jkve_pkg::PH_COPY || phase_r == jkve_pkg::PH_DONE)
    else $error("brace depth outside value copy");

endmodule

>>> rtl/json_key_value_extractor.sv
// ----------------------------------------------------------------------------
// json_key_value_extractor
// finds a configured key in a byte stream and copies out the value after it
//
//   channel | ports                                  | direction
//   in      | in_valid, in_stall, in_data            | text bytes in
//   out     | out_valid, out_stall, out_data         | value bytes / status out
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes in
//
// one byte per cycle while in_stall is low: the key compare and phase
// update sit between the state registers and the result register
// results are registered and appear in the cycle after the byte that causes them
// in_stall is high only while a result waits and out_stall is high
// synchronous active-low reset clears the phase, window and counters
// ----------------------------------------------------------------------------
module json_key_value_extractor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  jkve_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output jkve_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [jkve_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [63:0]                   cfg_data
);

  jkve_pkg::cfg_t        cfg_r;
  jkve_pkg::match_ctrl_t mctrl;
  jkve_pkg::out_item_t   res;
  jkve_pkg::out_item_t   out_data_r;
  logic                  res_valid;
  logic                  match;
  logic                  in_acc;
  logic                  out_valid_r, out_valid_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_pattern      <= '0;
      cfg_r.key_length       <= jkve_pkg::KLEN_W'(1);
      cfg_r.max_value_length <= 8'hff;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jkve_pkg::CFG_KEY_PATTERN: cfg_r.key_pattern      <= cfg_data;
        jkve_pkg::CFG_KEY_LENGTH:  cfg_r.key_length       <= cfg_data[jkve_pkg::KLEN_W-1:0];
        jkve_pkg::CFG_MAX_LENGTH:  cfg_r.max_value_length <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  jkve_key_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mctrl),
    .text_byte (in_data.text_byte),
    .cfg       (cfg_r),
    .match     (match)
  );

  jkve_extract_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .item      (in_data),
    .cfg       (cfg_r),
    .match     (match),
    .mctrl     (mctrl),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (in_acc && res_valid) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_data_r <= res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("pending result lost");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty result register");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_valid |=> out_valid_r && out_data_r == $past(res))
    else $error("result transfer not registered");

endmodule
